@@ design/srt_pkg.sv @@
package srt_pkg;

  // Table and time sizes.
  localparam int MAX_CHUNKS = 32;
  localparam int TIME_BITS  = 16;
  localparam int IDX_W      = $clog2(MAX_CHUNKS);
  localparam int CNT_W      = $clog2(MAX_CHUNKS + 1);

  // Fixed field widths of the ports.
  localparam int KIND_W     = 2;
  localparam int ACK_W      = 16;
  localparam int SEQ_W      = 6;
  localparam int CCOUNT_W   = 6;
  localparam int TOUT_W     = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;

  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [ACK_W-1:0]     ack_t;
  typedef logic [SEQ_W-1:0]     seq_t;
  typedef logic [TOUT_W-1:0]    tout_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_COUNT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 1'b1;

  localparam logic [CCOUNT_W-1:0] CHUNK_COUNT_RST   = 6'd1;
  localparam tout_t               TIMEOUT_TICKS_RST = 16'd100;

  // Input word kinds.
  typedef enum logic [KIND_W-1:0] {
    KIND_START = 2'd0,
    KIND_ACK   = 2'd1,
    KIND_TICK  = 2'd2
  } kind_e;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ACK_W-1:0]  ack_seq;
  } item_t;

  typedef struct packed {
    logic             send_request;
    logic [SEQ_W-1:0] chunk_seq;
    logic             is_retransmit;
    logic             all_acked;
    logic             last;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEND,
    ST_SCAN,
    ST_DRAIN,
    ST_FLUSH,
    ST_STATUS
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic clear_flags;
    logic ack;
    logic tick;
    logic send;
    logic scan;
    logic flush;
    logic status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_entry;
  } stat_t;

  // Effective chunk count: zero acts as one, large values clip to the table size.
  function automatic cnt_t eff_count(input logic [CCOUNT_W-1:0] c);
    cnt_t n;
    if (c == '0) begin
      n = cnt_t'(1);
    end else if (int'(c) > MAX_CHUNKS) begin
      n = cnt_t'(MAX_CHUNKS);
    end else begin
      n = cnt_t'(c);
    end
    return n;
  endfunction

  // One bit set for each chunk in use.
  function automatic logic [MAX_CHUNKS-1:0] chunk_mask(input cnt_t n);
    logic [MAX_CHUNKS-1:0] m;
    for (int i = 0; i < MAX_CHUNKS; i++) begin
      m[i] = (i < int'(n));
    end
    return m;
  endfunction

endpackage

@@ design/selective_repeat_retransmit_tracker_top.sv @@
// Channel   Handshake                          Payload
// input     start, busy (taken: start & !busy) item_i     (srt_pkg::item_t)
// result    result_valid_o, one cycle strobe   result_o   (srt_pkg::result_t)
// config    cfg_we_i, cfg_idx_i                cfg_data_i (16 bits)
//
// A start word holds the block busy through the walk over the chunk table, which
// gives one result per cycle and writes one send stamp per cycle. A tick word
// holds it through the scan (one stamp memory read per cycle), one compare stage
// and a flush state that releases the final held result. Ack and other words
// pass through the status state. Reset clears the table flags and the tick
// counter at once; the stamp memory is not cleared. Results cannot be stalled.
module selective_repeat_retransmit_tracker_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  srt_pkg::item_t                 item_i,
  output logic                           result_valid_o,
  output srt_pkg::result_t               result_o,
  input  logic                           cfg_we_i,
  input  logic [srt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [srt_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  srt_pkg::cmd_t  cmd;
  srt_pkg::stat_t stat;

  // Sequencer.
  srt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .kind_i (item_i.kind),
    .stat_i (stat),
    .busy   (busy),
    .cmd_o  (cmd)
  );

  // Table, timer and result path.
  srt_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .item_i         (item_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

@@ design/srt_ctrl.sv @@
module srt_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  input  logic [srt_pkg::KIND_W-1:0]     kind_i,
  input  srt_pkg::stat_t                 stat_i,
  output logic                           busy,
  output srt_pkg::cmd_t                  cmd_o
);

  srt_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= srt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != srt_pkg::ST_IDLE);

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      srt_pkg::ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          unique case (kind_i)
            srt_pkg::KIND_START: begin
              cmd_o.clear_flags = 1'b1;
              state_d           = srt_pkg::ST_SEND;
            end
            srt_pkg::KIND_ACK: begin
              cmd_o.ack = 1'b1;
              state_d   = srt_pkg::ST_STATUS;
            end
            srt_pkg::KIND_TICK: begin
              cmd_o.tick = 1'b1;
              state_d    = srt_pkg::ST_SCAN;
            end
            default: begin
              state_d = srt_pkg::ST_STATUS;
            end
          endcase
        end
      end
      srt_pkg::ST_SEND: begin
        cmd_o.send = 1'b1;
        if (stat_i.last_entry) begin
          state_d = srt_pkg::ST_IDLE;
        end
      end
      srt_pkg::ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.last_entry) begin
          state_d = srt_pkg::ST_DRAIN;
        end
      end
      srt_pkg::ST_DRAIN: begin
        // The last stamp read is compared in this cycle.
        state_d = srt_pkg::ST_FLUSH;
      end
      srt_pkg::ST_FLUSH: begin
        cmd_o.flush = 1'b1;
        state_d     = srt_pkg::ST_IDLE;
      end
      srt_pkg::ST_STATUS: begin
        cmd_o.status = 1'b1;
        state_d      = srt_pkg::ST_IDLE;
      end
      default: begin
        state_d = srt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ design/srt_dp.sv @@
module srt_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [srt_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [srt_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  srt_pkg::item_t                     item_i,
  input  srt_pkg::cmd_t                      cmd_i,
  output srt_pkg::stat_t                     stat_o,
  output logic                               result_valid_o,
  output srt_pkg::result_t                   result_o
);

  logic [srt_pkg::CCOUNT_W-1:0]   count_q;
  srt_pkg::tout_t                 timeout_q;
  logic [srt_pkg::MAX_CHUNKS-1:0] flags_q;
  srt_pkg::time_t                 now_q;
  srt_pkg::cnt_t                  n_q;
  srt_pkg::cnt_t                  idx_q;
  logic                           cmp_v_q;
  srt_pkg::idx_t                  cmp_idx_q;
  logic                           pend_v_q;
  srt_pkg::seq_t                  pend_seq_q;
  srt_pkg::time_t                 rd_data_q;
  logic                           res_v_q;
  srt_pkg::result_t               res_q, res_d;

  srt_pkg::time_t                 stamp_mem [srt_pkg::MAX_CHUNKS];

  srt_pkg::cnt_t                  n_cfg;
  logic                           ack_ok;
  srt_pkg::idx_t                  ack_idx;
  srt_pkg::idx_t                  scan_idx;
  srt_pkg::time_t                 age;
  logic                           hit;
  logic                           done;
  logic                           emit;
  logic                           mem_we;
  srt_pkg::idx_t                  mem_wa;
  srt_pkg::seq_t                  hit_seq;

  // Chunk count in effect for the next word, and the ack range check.
  assign n_cfg   = srt_pkg::eff_count(count_q);
  assign ack_ok  = (item_i.ack_seq != '0) &&
                   (item_i.ack_seq <= srt_pkg::ack_t'(n_cfg));
  assign ack_idx = srt_pkg::idx_t'(item_i.ack_seq - srt_pkg::ack_t'(1));

  assign scan_idx          = idx_q[srt_pkg::IDX_W-1:0];
  assign stat_o.last_entry = ((idx_q + srt_pkg::cnt_t'(1)) == n_q);

  // Retransmit test on the stamp read in the previous cycle.
  assign age     = now_q - rd_data_q;
  assign hit     = cmp_v_q && !flags_q[cmp_idx_q] && (age >= timeout_q);
  assign hit_seq = srt_pkg::seq_t'(srt_pkg::cnt_t'(cmp_idx_q) + srt_pkg::cnt_t'(1));

  // All chunks in use acknowledged.
  assign done = &(flags_q | ~srt_pkg::chunk_mask(n_q));

  // Stamp write: first sends during a start, restamps during a tick scan.
  assign mem_we = cmd_i.send || hit;
  assign mem_wa = cmd_i.send ? scan_idx : cmp_idx_q;

  // Result selection. A retransmission is held back one find so that the
  // final one can carry last.
  always_comb begin
    emit  = 1'b0;
    res_d = res_q;
    if (cmd_i.send) begin
      emit  = 1'b1;
      res_d = '{send_request: 1'b1,
                chunk_seq: srt_pkg::seq_t'(idx_q + srt_pkg::cnt_t'(1)),
                is_retransmit: 1'b0,
                all_acked: 1'b0,
                last: stat_o.last_entry};
    end else if (cmd_i.flush) begin
      emit  = 1'b1;
      res_d = '{send_request: pend_v_q,
                chunk_seq: pend_v_q ? pend_seq_q : '0,
                is_retransmit: pend_v_q,
                all_acked: done,
                last: 1'b1};
    end else if (cmd_i.status) begin
      emit  = 1'b1;
      res_d = '{send_request: 1'b0,
                chunk_seq: '0,
                is_retransmit: 1'b0,
                all_acked: done,
                last: 1'b1};
    end else if (hit && pend_v_q) begin
      emit  = 1'b1;
      res_d = '{send_request: 1'b1,
                chunk_seq: pend_seq_q,
                is_retransmit: 1'b1,
                all_acked: done,
                last: 1'b0};
    end
  end

  // Control and table state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= srt_pkg::CHUNK_COUNT_RST;
      timeout_q  <= srt_pkg::TIMEOUT_TICKS_RST;
      flags_q    <= '0;
      now_q      <= '0;
      n_q        <= srt_pkg::cnt_t'(1);
      idx_q      <= '0;
      cmp_v_q    <= 1'b0;
      cmp_idx_q  <= '0;
      pend_v_q   <= 1'b0;
      pend_seq_q <= '0;
      res_v_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          srt_pkg::CFG_CHUNK_COUNT:   count_q   <= cfg_data_i[srt_pkg::CCOUNT_W-1:0];
          srt_pkg::CFG_TIMEOUT_TICKS: timeout_q <= cfg_data_i[srt_pkg::TOUT_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.clear_flags) begin
        flags_q <= '0;
      end else if (cmd_i.ack && ack_ok) begin
        flags_q[ack_idx] <= 1'b1;
      end
      if (cmd_i.tick) begin
        now_q <= now_q + srt_pkg::time_t'(1);
      end
      if (cmd_i.load) begin
        n_q   <= n_cfg;
        idx_q <= '0;
      end else if (cmd_i.send || cmd_i.scan) begin
        idx_q <= idx_q + srt_pkg::cnt_t'(1);
      end
      cmp_v_q   <= cmd_i.scan;
      cmp_idx_q <= scan_idx;
      if (cmd_i.load) begin
        pend_v_q <= 1'b0;
      end else if (hit) begin
        pend_v_q   <= 1'b1;
        pend_seq_q <= hit_seq;
      end
      res_v_q <= emit;
    end
  end

  // Send stamp memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      stamp_mem[mem_wa] <= now_q;
    end
    if (cmd_i.scan) begin
      rd_data_q <= stamp_mem[scan_idx];
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_q <= res_d;
    end
  end

  assign result_valid_o = res_v_q;
  assign result_o       = res_q;

endmodule

@@ design/srt_checker.sv @@
module srt_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input logic             result_valid_o,
  input srt_pkg::result_t result_o
);

  // An accepted word keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("block not busy after an accepted word");

  // A result that is not the final one of its word arrives while still busy.
  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.last) |-> busy)
    else $error("non-final result while idle");

  // Going idle coincides with the final result of the word.
  a_idle_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> (result_valid_o && result_o.last))
    else $error("went idle without a final result");

  // A status result names no chunk; a send names a real chunk.
  a_seq_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_o.send_request ?
      (result_o.chunk_seq != '0) :
      ((result_o.chunk_seq == '0) && !result_o.is_retransmit)))
    else $error("chunk number does not match send request");

endmodule

bind selective_repeat_retransmit_tracker_top srt_checker u_srt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);

@@ sim/tracker_monitor.sv @@
// Watches the word, result and register channels of the retransmit tracker,
// predicts every result word and compares it with what the block sends.
module tracker_monitor (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic                           busy_i,
  input  srt_pkg::item_t                 item_i,
  input  logic                           cfg_we_i,
  input  logic [srt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [srt_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           result_valid_i,
  input  srt_pkg::result_t               result_i,
  output int                             mismatch_count_o,
  output int                             awaited_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the registers and the chunk table.
  logic [srt_pkg::CCOUNT_W-1:0]   chunk_count_q;
  srt_pkg::tout_t                 timeout_q;
  logic [srt_pkg::MAX_CHUNKS-1:0] acked_q;
  srt_pkg::time_t                 stamp_q [srt_pkg::MAX_CHUNKS];
  srt_pkg::time_t                 now_q;
  logic [srt_pkg::CCOUNT_W-1:0]   acked_total_q;

  // Result words predicted but not yet seen, oldest first.
  srt_pkg::result_t awaited_results [$];
  int               mismatches;

  // Zero acts as one chunk, anything above the table size clips to it.
  function automatic int chunks_in_use();
    if (chunk_count_q == '0) begin
      return 1;
    end
    if (int'(chunk_count_q) > srt_pkg::MAX_CHUNKS) begin
      return srt_pkg::MAX_CHUNKS;
    end
    return int'(chunk_count_q);
  endfunction

  function automatic logic transfer_complete(input int n);
    for (int i = 0; i < n; i++) begin
      if (!acked_q[i]) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic srt_pkg::result_t make_result(input logic req, input int seq,
                                                   input logic retx, input logic done,
                                                   input logic fin);
    srt_pkg::result_t r;
    r.send_request  = req;
    r.chunk_seq     = srt_pkg::SEQ_W'(seq);
    r.is_retransmit = retx;
    r.all_acked     = done;
    r.last          = fin;
    return r;
  endfunction

  // Apply one accepted word to the shadow state and queue the words it causes.
  task automatic plan_results(input srt_pkg::item_t w);
    int                             n;
    int                             retx_total;
    int                             retx_seen;
    logic                           complete;
    logic [srt_pkg::MAX_CHUNKS-1:0] due;
    n          = chunks_in_use();
    due        = '0;
    retx_total = 0;
    retx_seen  = 0;
    case (w.kind)
      srt_pkg::KIND_START: begin
        acked_q       = '0;
        acked_total_q = '0;
        for (int i = 0; i < n; i++) begin
          stamp_q[i] = now_q;
          awaited_results.push_back(make_result(1'b1, i + 1, 1'b0, 1'b0, i == n - 1));
        end
      end
      srt_pkg::KIND_ACK: begin
        // Out-of-range and repeated acks leave the table alone.
        if (w.ack_seq >= 1 && int'(w.ack_seq) <= n) begin
          if (!acked_q[int'(w.ack_seq) - 1]) begin
            acked_q[int'(w.ack_seq) - 1] = 1'b1;
            acked_total_q = acked_total_q + srt_pkg::CCOUNT_W'(1);
          end
        end
        awaited_results.push_back(make_result(1'b0, 0, 1'b0, transfer_complete(n), 1'b1));
      end
      srt_pkg::KIND_TICK: begin
        // Age is taken modulo the counter width, so it survives the wrap.
        now_q = now_q + srt_pkg::TIME_BITS'(1);
        for (int i = 0; i < n; i++) begin
          if (!acked_q[i] && srt_pkg::time_t'(now_q - stamp_q[i]) >= timeout_q) begin
            stamp_q[i] = now_q;
            due[i]     = 1'b1;
            retx_total++;
          end
        end
        complete = transfer_complete(n);
        if (retx_total == 0) begin
          awaited_results.push_back(make_result(1'b0, 0, 1'b0, complete, 1'b1));
        end else begin
          for (int i = 0; i < n; i++) begin
            if (due[i]) begin
              retx_seen++;
              awaited_results.push_back(make_result(1'b1, i + 1, 1'b1, complete,
                                                    retx_seen == retx_total));
            end
          end
        end
      end
      default: begin
        awaited_results.push_back(make_result(1'b0, 0, 1'b0, transfer_complete(n), 1'b1));
      end
    endcase
  endtask

  // Compare results first: a result at this edge always belongs to an older word.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    srt_pkg::result_t oldest;
    if (!rst_ni) begin
      chunk_count_q = srt_pkg::CHUNK_COUNT_RST;
      timeout_q     = srt_pkg::TIMEOUT_TICKS_RST;
      acked_q       = '0;
      now_q         = '0;
      acked_total_q = '0;
      for (int i = 0; i < srt_pkg::MAX_CHUNKS; i++) begin
        stamp_q[i] = '0;
      end
      awaited_results.delete();
      mismatches = 0;
    end else begin
      if (result_valid_i) begin
        if (awaited_results.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: result word with none awaited: %s req=%0b seq=%0d",
                     $time, "", result_i.send_request, result_i.chunk_seq);
            $display("%0t:           retx=%0b done=%0b last=%0b",
                     $time, result_i.is_retransmit, result_i.all_acked, result_i.last);
          end
          mismatches++;
        end else begin
          oldest = awaited_results.pop_front();
          if (result_i.send_request  !== oldest.send_request  ||
              result_i.chunk_seq     !== oldest.chunk_seq     ||
              result_i.is_retransmit !== oldest.is_retransmit ||
              result_i.all_acked     !== oldest.all_acked     ||
              result_i.last          !== oldest.last) begin
            if (mismatches < 10) begin
              $display("%0t: mismatch, expected req=%0b seq=%0d retx=%0b done=%0b last=%0b",
                       $time, oldest.send_request, oldest.chunk_seq,
                       oldest.is_retransmit, oldest.all_acked, oldest.last);
              $display("%0t:           got      req=%0b seq=%0d retx=%0b done=%0b last=%0b",
                       $time, result_i.send_request, result_i.chunk_seq,
                       result_i.is_retransmit, result_i.all_acked, result_i.last);
            end
            mismatches++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          srt_pkg::CFG_CHUNK_COUNT:   chunk_count_q = cfg_data_i[srt_pkg::CCOUNT_W-1:0];
          srt_pkg::CFG_TIMEOUT_TICKS: timeout_q     = cfg_data_i[srt_pkg::TOUT_W-1:0];
          default: ;
        endcase
      end
      if (start_i && !busy_i) begin
        plan_results(item_i);
      end
    end
    mismatch_count_o <= mismatches;
    awaited_count_o  <= awaited_results.size();
  end

endmodule

@@ sim/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [srt_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

  logic                           clk;
  logic                           rst_n    = 1'b0;
  logic                           start    = 1'b0;
  logic                           busy;
  srt_pkg::item_t                 item     = '0;
  logic                           result_valid;
  srt_pkg::result_t               result;
  logic                           cfg_we   = 1'b0;
  logic [srt_pkg::CFG_IDX_W-1:0]  cfg_idx  = srt_pkg::CFG_CHUNK_COUNT;
  logic [srt_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  int                             mismatches;
  int                             awaited;

  // Sender pacing and what the stimulus knows of the table.
  int idle_pct       = 0;
  int chunks_now     = 1;
  int chunks_stamped = 0;

  selective_repeat_retransmit_tracker_top dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start          (start),
    .busy           (busy),
    .item_i         (item),
    .result_valid_o (result_valid),
    .result_o       (result),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data)
  );

  tracker_monitor u_monitor (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .start_i          (start),
    .busy_i           (busy),
    .item_i           (item),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .result_valid_i   (result_valid),
    .result_i         (result),
    .mismatch_count_o (mismatches),
    .awaited_count_o  (awaited)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Entered and left at a falling edge; start stays high into the next call.
  task automatic send_word(input logic [srt_pkg::KIND_W-1:0] kind,
                           input logic [srt_pkg::ACK_W-1:0]  ack);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start        <= 1'b1;
    item.kind    <= kind;
    item.ack_seq <= ack;
    do @(posedge clk); while (busy);
    if (kind == srt_pkg::KIND_START && chunks_now > chunks_stamped) begin
      chunks_stamped = chunks_now;
    end
    @(negedge clk);
  endtask

  // Drop start and wait until the block has gone quiet.
  task automatic settle();
    start <= 1'b0;
    @(negedge clk);
    while (awaited != 0 || busy) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [srt_pkg::CFG_IDX_W-1:0]  idx,
                           input logic [srt_pkg::CFG_DATA_W-1:0] data);
    logic [srt_pkg::CCOUNT_W-1:0] c;
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    if (idx == srt_pkg::CFG_CHUNK_COUNT) begin
      c          = data[srt_pkg::CCOUNT_W-1:0];
      chunks_now = (c == '0) ? 1 :
                   (int'(c) > srt_pkg::MAX_CHUNKS) ? srt_pkg::MAX_CHUNKS : int'(c);
    end
  endtask

  task automatic configure(input logic [srt_pkg::CFG_DATA_W-1:0] count,
                           input logic [srt_pkg::CFG_DATA_W-1:0] tout);
    settle();
    write_reg(srt_pkg::CFG_CHUNK_COUNT, count);
    write_reg(srt_pkg::CFG_TIMEOUT_TICKS, tout);
  endtask

  // Mostly short transfers; now and then the full table, zero or an oversize count.
  function automatic logic [srt_pkg::CFG_DATA_W-1:0] pick_count();
    int                           r;
    logic [srt_pkg::CCOUNT_W-1:0] c;
    logic [9:0]                   upper;
    r = $urandom_range(99);
    if (r < 70) begin
      c = srt_pkg::CCOUNT_W'($urandom_range(8, 1));
    end else if (r < 80) begin
      c = srt_pkg::CCOUNT_W'(srt_pkg::MAX_CHUNKS);
    end else if (r < 85) begin
      c = '0;
    end else if (r < 92) begin
      c = srt_pkg::CCOUNT_W'($urandom_range(63, 33));
    end else begin
      c = srt_pkg::CCOUNT_W'($urandom_range(31, 9));
    end
    upper = $urandom_range(1) ? 10'($urandom) : '0;
    return {upper, c};
  endfunction

  function automatic logic [srt_pkg::CFG_DATA_W-1:0] pick_timeout();
    int r;
    r = $urandom_range(99);
    if (r < 15) begin
      return '0;
    end else if (r < 75) begin
      return srt_pkg::CFG_DATA_W'($urandom_range(4, 1));
    end else if (r < 90) begin
      return srt_pkg::CFG_DATA_W'($urandom_range(40, 5));
    end
    return 16'hFFFF;
  endfunction

  // One word inside a transfer: mostly acks and ticks, some noise and restarts.
  // A tick is held back while the count has grown past the stamped chunks.
  task automatic send_random_word();
    int                          r;
    logic [srt_pkg::ACK_W-1:0]   a;
    r = $urandom_range(99);
    if (r < 45 || (r < 80 && chunks_now > chunks_stamped)) begin
      send_word(srt_pkg::KIND_ACK, srt_pkg::ACK_W'($urandom_range(chunks_now, 1)));
    end else if (r < 80) begin
      send_word(srt_pkg::KIND_TICK, srt_pkg::ACK_W'($urandom));
    end else if (r < 88) begin
      a = ($urandom_range(3) == 0) ? '0 :
          srt_pkg::ACK_W'($urandom_range(65535, chunks_now + 1));
      send_word(srt_pkg::KIND_ACK, a);
    end else if (r < 93) begin
      send_word(KIND_UNUSED, srt_pkg::ACK_W'($urandom));
    end else begin
      send_word(srt_pkg::KIND_START, srt_pkg::ACK_W'($urandom));
    end
  endtask

  initial begin
    int words;
    int burst;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: ack and unused kind before any start, then the reset settings.
    send_word(srt_pkg::KIND_ACK, 16'd1);
    send_word(KIND_UNUSED, 16'hFFFF);
    send_word(srt_pkg::KIND_START, 16'h0000);
    send_word(srt_pkg::KIND_TICK, 16'h0000);

    // Full table with zero timeout: every open chunk goes out on each tick.
    configure(16'd32, 16'd0);
    send_word(srt_pkg::KIND_START, 16'hFFFF);
    send_word(srt_pkg::KIND_TICK, 16'h0000);
    send_word(srt_pkg::KIND_ACK, 16'd32);
    send_word(srt_pkg::KIND_ACK, 16'd1);
    send_word(srt_pkg::KIND_ACK, 16'd1);
    send_word(srt_pkg::KIND_ACK, 16'd0);
    send_word(srt_pkg::KIND_ACK, 16'd33);
    send_word(srt_pkg::KIND_ACK, 16'hFFFF);
    send_word(srt_pkg::KIND_TICK, 16'h0000);

    // Count zero behaves as one chunk; the upper data bits are not part of it.
    configure(16'hFFC0, 16'd1);
    send_word(srt_pkg::KIND_TICK, 16'h0000);
    send_word(srt_pkg::KIND_START, 16'h0000);
    send_word(srt_pkg::KIND_TICK, 16'h0000);
    send_word(srt_pkg::KIND_ACK, 16'd1);
    send_word(srt_pkg::KIND_TICK, 16'h0000);

    // Oversize count in the middle of a transfer clips to the table size.
    settle();
    write_reg(srt_pkg::CFG_CHUNK_COUNT, 16'd63);
    send_word(srt_pkg::KIND_TICK, 16'h0000);

    // Longest timeout.
    configure(16'd5, 16'hFFFF);
    send_word(srt_pkg::KIND_START, 16'h0000);
    send_word(srt_pkg::KIND_TICK, 16'h0000);
    send_word(srt_pkg::KIND_ACK, 16'd2);
    send_word(KIND_UNUSED, 16'h0000);

    // Random transfers under three sender paces.
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 17 : (phase == 1) ? 84 : 0;
      words    = 0;
      while (words < 90) begin
        if (words == 0 || $urandom_range(2) == 0) begin
          configure(pick_count(), pick_timeout());
        end
        send_word(srt_pkg::KIND_START, srt_pkg::ACK_W'($urandom));
        words++;
        burst = $urandom_range(30, 6);
        repeat (burst) begin
          if ($urandom_range(99) < 3) begin
            settle();
            write_reg(srt_pkg::CFG_CHUNK_COUNT, pick_count());
          end
          send_random_word();
          words++;
        end
      end
    end

    settle();
    repeat (8) @(negedge clk);
    if (mismatches == 0 && awaited == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #8_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
